// ----- hw/rtl/ppa_pkg.sv -----
// Shared types, widths and constant tables for the polar phasor adder.
// Depends on nothing; every other file in the block imports it.
package ppa_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int MAG_W             = 32;
    localparam int PH_W              = 16;
    localparam int GUARD_BITS        = 4;
    localparam int GAIN_FRAC         = 26;
    localparam int GAIN_W            = GAIN_FRAC + 1;
    localparam int ROT_W             = 39;
    localparam int ROT_ZW            = 32;
    localparam int VEC_W             = 42;
    localparam int VEC_ZW            = 34;

    typedef struct packed {
        logic [MAG_W-1:0] first_magnitude;
        logic [PH_W-1:0]  first_phase;
        logic [MAG_W-1:0] second_magnitude;
        logic [PH_W-1:0]  second_phase;
    } t_in;

    typedef struct packed {
        logic [MAG_W-1:0] sum_magnitude;
        logic [PH_W-1:0]  sum_phase;
        logic             saturated;
    } t_out;

    typedef struct packed {
        logic             byp;
        logic             zero;
        logic [MAG_W-1:0] mag;
        logic [PH_W-1:0]  phase;
        logic             sat;
    } t_side;

    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    localparam logic [63:0] GSQ_0  = 64'd1 << GAIN_FRAC;
    localparam logic [63:0] GSQ_1  = GSQ_0 / 64'd2;
    localparam logic [63:0] GSQ_2  = (GSQ_1 << 2) / 64'd5;
    localparam logic [63:0] GSQ_3  = (GSQ_2 << 4) / 64'd17;
    localparam logic [63:0] GSQ_4  = (GSQ_3 << 6) / 64'd65;
    localparam logic [63:0] GSQ_5  = (GSQ_4 << 8) / 64'd257;
    localparam logic [63:0] GSQ_6  = (GSQ_5 << 10) / 64'd1025;
    localparam logic [63:0] GSQ_7  = (GSQ_6 << 12) / 64'd4097;
    localparam logic [63:0] GSQ_8  = (GSQ_7 << 14) / 64'd16385;
    localparam logic [63:0] GSQ_9  = (GSQ_8 << 16) / 64'd65537;
    localparam logic [63:0] GSQ_10 = (GSQ_9 << 18) / 64'd262145;
    localparam logic [63:0] GSQ_11 = (GSQ_10 << 20) / 64'd1048577;
    localparam logic [63:0] GSQ_12 = (GSQ_11 << 22) / 64'd4194305;
    localparam logic [63:0] GSQ_13 = (GSQ_12 << 24) / 64'd16777217;
    localparam logic [63:0] GSQ_14 = (GSQ_13 << 26) / 64'd67108865;
    localparam logic [63:0] GSQ_15 = (GSQ_14 << 28) / 64'd268435457;
    localparam logic [63:0] GSQ_16 = (GSQ_15 << 30) / 64'd1073741825;

    localparam logic [GAIN_W-1:0] INV_GAIN_SQ [17] = '{
        GSQ_0[GAIN_W-1:0],  GSQ_1[GAIN_W-1:0],  GSQ_2[GAIN_W-1:0],  GSQ_3[GAIN_W-1:0],
        GSQ_4[GAIN_W-1:0],  GSQ_5[GAIN_W-1:0],  GSQ_6[GAIN_W-1:0],  GSQ_7[GAIN_W-1:0],
        GSQ_8[GAIN_W-1:0],  GSQ_9[GAIN_W-1:0],  GSQ_10[GAIN_W-1:0], GSQ_11[GAIN_W-1:0],
        GSQ_12[GAIN_W-1:0], GSQ_13[GAIN_W-1:0], GSQ_14[GAIN_W-1:0], GSQ_15[GAIN_W-1:0],
        GSQ_16[GAIN_W-1:0]
    };

    function automatic logic [GAIN_W-1:0] inv_gain_sq(int n);
        return INV_GAIN_SQ[(n > 16) ? 16 : ((n < 0) ? 0 : n)];
    endfunction

endpackage

// ----- hw/rtl/polar_phasor_adder.sv -----
// Polar phasor adder: sums two polar vectors (Q16.16 magnitude, phase as a 16-bit
// fraction of a turn) and returns the sum in polar form with a saturation flag.
// One transaction enters per cycle unless the output stalls; each passes in order through the
// input register, the rotation CORDIC stages, the sum register, the vectoring CORDIC
// stages and the two-stage gain multiplier. A stall on the output freezes the whole
// pipeline and is passed straight back as the input stall.
// Depends on ppa_pkg, ppa_cordic_stage and ppa_gain.
module polar_phasor_adder #(
    parameter int CORDIC_STAGES = ppa_pkg::CORDIC_STAGES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  ppa_pkg::t_in   i_in_data,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output ppa_pkg::t_out  o_out_data,
    input  logic           i_out_stall
);
    import ppa_pkg::*;

    localparam int N = CORDIC_STAGES;
    localparam logic [1:0] QUAD_XPOS = 2'd0;
    localparam logic [1:0] QUAD_YPOS = 2'd1;
    localparam logic [1:0] QUAD_XNEG = 2'd2;
    localparam logic [1:0] QUAD_YNEG = 2'd3;

    logic en;

    logic                   rv [N+1];
    t_side                  rs [N+1];
    logic [1:0][ROT_W-1:0]  rx [N+1];
    logic [1:0][ROT_W-1:0]  ry [N+1];
    logic [1:0][ROT_ZW-1:0] rz [N+1];

    logic                   vv [N+1];
    t_side                  vs [N+1];
    logic [0:0][VEC_W-1:0]  vx [N+1];
    logic [0:0][VEC_W-1:0]  vy [N+1];
    logic [0:0][VEC_ZW-1:0] vz [N+1];

    t_side                  n_side;
    logic [1:0][ROT_W-1:0]  n_x0, n_y0;
    logic [1:0][ROT_ZW-1:0] n_z0;
    logic [MAG_W:0]         msum;

    assign en         = !(o_out_valid && i_out_stall);
    assign o_in_stall = !en;

    always_comb begin
        logic [MAG_W-1:0] m [2];
        logic [PH_W-1:0]  p [2];
        logic [ROT_W-1:0] mw;
        m[0] = i_in_data.first_magnitude;
        m[1] = i_in_data.second_magnitude;
        p[0] = i_in_data.first_phase;
        p[1] = i_in_data.second_phase;
        msum = {1'b0, m[0]} + {1'b0, m[1]};
        n_side      = '0;
        n_side.byp  = 1'b1;
        if (m[0] == '0) begin
            n_side.mag   = m[1];
            n_side.phase = (m[1] != '0) ? p[1] : p[0];
        end else if (m[1] == '0) begin
            n_side.mag   = m[0];
            n_side.phase = p[0];
        end else if (p[0] == p[1]) begin
            n_side.mag   = msum[MAG_W] ? '1 : msum[MAG_W-1:0];
            n_side.phase = p[0];
            n_side.sat   = msum[MAG_W];
        end else begin
            n_side.byp = 1'b0;
        end
        for (int l = 0; l < 2; l++) begin
            mw      = ROT_W'({m[l], {GUARD_BITS{1'b0}}});
            n_z0[l] = ROT_ZW'({p[l][PH_W-3:0], 16'h0000});
            unique case (p[l][PH_W-1:PH_W-2])
                QUAD_XPOS: begin n_x0[l] = mw;  n_y0[l] = '0;  end
                QUAD_YPOS: begin n_x0[l] = '0;  n_y0[l] = mw;  end
                QUAD_XNEG: begin n_x0[l] = -mw; n_y0[l] = '0;  end
                QUAD_YNEG: begin n_x0[l] = '0;  n_y0[l] = -mw; end
                default:   begin n_x0[l] = '0;  n_y0[l] = '0;  end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rv[0] <= 1'b0;
        end else if (en) begin
            rv[0] <= i_in_valid;
        end
        if (en) begin
            rs[0] <= n_side;
            rx[0] <= n_x0;
            ry[0] <= n_y0;
            rz[0] <= n_z0;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_rot
        ppa_cordic_stage #(
            .LANES(2), .DW(ROT_W), .AW(ROT_ZW), .IDX(k), .VECTOR(1'b0)
        ) u_rot (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_valid(rv[k]), .i_side(rs[k]),
            .i_x(rx[k]), .i_y(ry[k]), .i_z(rz[k]),
            .o_valid(rv[k+1]), .o_side(rs[k+1]),
            .o_x(rx[k+1]), .o_y(ry[k+1]), .o_z(rz[k+1])
        );
    end

    t_side              n_vside;
    logic [VEC_W-1:0]   sx, sy;

    always_comb begin
        sx = VEC_W'($signed(rx[N][0])) + VEC_W'($signed(rx[N][1]));
        sy = VEC_W'($signed(ry[N][0])) + VEC_W'($signed(ry[N][1]));
        n_vside      = rs[N];
        n_vside.zero = (sx == '0) && (sy == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            vv[0] <= 1'b0;
        end else if (en) begin
            vv[0] <= rv[N];
        end
        if (en) begin
            vs[0] <= n_vside;
            if (sx[VEC_W-1]) begin
                vx[0][0] <= -sx;
                vy[0][0] <= -sy;
                vz[0][0] <= VEC_ZW'(33'h0_8000_0000);
            end else begin
                vx[0][0] <= sx;
                vy[0][0] <= sy;
                vz[0][0] <= '0;
            end
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_vec
        ppa_cordic_stage #(
            .LANES(1), .DW(VEC_W), .AW(VEC_ZW), .IDX(k), .VECTOR(1'b1)
        ) u_vec (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_valid(vv[k]), .i_side(vs[k]),
            .i_x(vx[k]), .i_y(vy[k]), .i_z(vz[k]),
            .o_valid(vv[k+1]), .o_side(vs[k+1]),
            .o_x(vx[k+1]), .o_y(vy[k+1]), .o_z(vz[k+1])
        );
    end

    ppa_gain #(.STAGES(N)) u_gain (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(vv[N]), .i_side(vs[N]),
        .i_x(vx[N][0]), .i_z(vz[N][0]),
        .o_valid(o_out_valid), .o_data(o_out_data)
    );

`ifndef NO_ASSERTIONS
    a_sat_clamps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.saturated |-> o_out_data.sum_magnitude == '1)
        else $error("saturated result not clamped");
    a_stall_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall == (o_out_valid && i_out_stall))
        else $error("input stall does not follow output backpressure");
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> $stable(rv[0]) && $stable(vv[0]))
        else $error("pipeline advanced while stalled");
`endif

endmodule

// ----- hw/rtl/ppa_cordic_stage.sv -----
// One registered CORDIC micro-rotation over one or more lanes, rotation or vectoring.
// Depends on ppa_pkg for the arctangent table and the side-band type.
module ppa_cordic_stage #(
    parameter int LANES  = 1,
    parameter int DW     = 39,
    parameter int AW     = 32,
    parameter int IDX    = 0,
    parameter bit VECTOR = 1'b0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  ppa_pkg::t_side                i_side,
    input  logic [LANES-1:0][DW-1:0]      i_x,
    input  logic [LANES-1:0][DW-1:0]      i_y,
    input  logic [LANES-1:0][AW-1:0]      i_z,
    output logic                          o_valid,
    output ppa_pkg::t_side                o_side,
    output logic [LANES-1:0][DW-1:0]      o_x,
    output logic [LANES-1:0][DW-1:0]      o_y,
    output logic [LANES-1:0][AW-1:0]      o_z
);
    import ppa_pkg::*;

    localparam logic [AW-1:0] ANGLE = AW'(ATAN_TURNS[IDX]);

    logic                     r_valid;
    t_side                    r_side;
    logic [LANES-1:0][DW-1:0] r_x, r_y, n_x, n_y;
    logic [LANES-1:0][AW-1:0] r_z, n_z;

    always_comb begin
        logic signed [DW-1:0] xs, ys, dx, dy;
        logic                 pos;
        for (int l = 0; l < LANES; l++) begin
            xs  = $signed(i_x[l]);
            ys  = $signed(i_y[l]);
            dx  = ys >>> IDX;
            dy  = xs >>> IDX;
            pos = VECTOR ? i_y[l][DW-1] : !i_z[l][AW-1];
            if (pos) begin
                n_x[l] = i_x[l] - dx;
                n_y[l] = i_y[l] + dy;
                n_z[l] = i_z[l] - ANGLE;
            end else begin
                n_x[l] = i_x[l] + dx;
                n_y[l] = i_y[l] - dy;
                n_z[l] = i_z[l] + ANGLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_side <= i_side;
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;

endmodule

// ----- hw/rtl/ppa_gain.sv -----
// Two-stage gain correction, rounding, saturation and result select.
// Depends on ppa_pkg for widths, the gain function and the result types.
module ppa_gain #(
    parameter int STAGES = ppa_pkg::CORDIC_STAGES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  ppa_pkg::t_side              i_side,
    input  logic [ppa_pkg::VEC_W-1:0]   i_x,
    input  logic [ppa_pkg::VEC_ZW-1:0]  i_z,
    output logic                        o_valid,
    output ppa_pkg::t_out               o_data
);
    import ppa_pkg::*;

    localparam logic [GAIN_W-1:0] GAIN = inv_gain_sq(STAGES);
    localparam int XW    = VEC_W - 1;
    localparam int LO    = (XW + 1) / 2;
    localparam int HI    = XW - LO;
    localparam int PW    = XW + GAIN_W + 1;
    localparam int SHIFT = GAIN_FRAC + GUARD_BITS;

    logic                   r_valid_a, r_valid_b;
    t_side                  r_side_a;
    logic [LO+GAIN_W-1:0]   r_plo;
    logic [HI+GAIN_W-1:0]   r_phi;
    logic [PH_W-1:0]        r_phase_a;
    t_out                   r_out, n_out;
    logic [XW-1:0]          xc;
    logic [VEC_ZW-1:0]      zr;
    logic [PW-1:0]          prod;
    logic [PW-1:0]          scaled;

    assign xc = i_x[VEC_W-1] ? '0 : i_x[XW-1:0];
    assign zr = i_z + VEC_ZW'(32'h8000);

    always_comb begin
        prod   = PW'(r_plo) + (PW'(r_phi) << LO) + (PW'(1) << (SHIFT - 1));
        scaled = prod >> SHIFT;
        if (r_side_a.byp) begin
            n_out.sum_magnitude = r_side_a.mag;
            n_out.sum_phase     = r_side_a.phase;
            n_out.saturated     = r_side_a.sat;
        end else if (r_side_a.zero) begin
            n_out = '0;
        end else begin
            n_out.sum_phase = r_phase_a;
            if (|scaled[PW-1:MAG_W]) begin
                n_out.sum_magnitude = '1;
                n_out.saturated     = 1'b1;
            end else begin
                n_out.sum_magnitude = scaled[MAG_W-1:0];
                n_out.saturated     = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else if (i_en) begin
            r_valid_a <= i_valid;
            r_valid_b <= r_valid_a;
        end
        if (i_en) begin
            r_side_a  <= i_side;
            r_plo     <= xc[LO-1:0] * GAIN;
            r_phi     <= xc[XW-1:LO] * GAIN;
            r_phase_a <= zr[31:16];
            r_out     <= n_out;
        end
    end

    assign o_valid = r_valid_b;
    assign o_data  = r_out;

endmodule
